// ===== rtl/core/ckmer_pkg.sv =====
// Package: shared types, constants and helpers for the canonical k-mer stream.
`default_nettype none

package ckmer_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned KMaxPairs = 32;
  localparam int unsigned KLenW    = 6;
  localparam int unsigned KIdxW    = 5;
  localparam int unsigned OutPosW  = 32;

  // Reset length is 31 bases, held as k-1.
  localparam logic [KIdxW-1:0] KM1Reset = 5'd30;

  // Item passed from the front end to the back end.
  typedef struct packed {
    logic [WordW-1:0]   fwd_word;
    logic [WordW-1:0]   rc_word;
    logic [OutPosW-1:0] start_pos;
    logic               last;
  } ckmer_item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } ckmer_q_stat_t;

  // Clamp a written length to 1..32 and return k-1.
  function automatic logic [KIdxW-1:0] eff_km1(input logic [KLenW-1:0] len);
    logic [KIdxW-1:0] r;
    if (len == '0) begin
      r = '0;
    end else if (len > 6'd32) begin
      r = 5'd31;
    end else begin
      r = KIdxW'(len - 6'd1);
    end
    return r;
  endfunction

  // Mask covering the low 2*k bits of a word.
  function automatic logic [WordW-1:0] word_mask(input logic [KIdxW-1:0] km1);
    logic [WordW-1:0] m;
    m = '0;
    for (int i = 0; i < KMaxPairs; i++) begin
      if (KIdxW'(i) <= km1) begin
        m[2*i +: 2] = 2'b11;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ckmer_in_if.sv =====
// Interface: base input channel.
`default_nettype none

interface ckmer_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] base;
  logic       contig_end;

  modport source (output valid, output base, output contig_end, input ready);
  modport sink (input valid, input base, input contig_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ckmer_out_if.sv =====
// Interface: canonical k-mer result channel.
`default_nettype none

interface ckmer_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] canonical_word;
  logic [31:0] start_pos;
  logic        forward_is_canonical;
  logic        last_of_contig;

  modport source (output valid, output canonical_word, output start_pos,
                  output forward_is_canonical, output last_of_contig, input ready);
  modport sink (input valid, input canonical_word, input start_pos,
                input forward_is_canonical, input last_of_contig, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ckmer_cfg_if.sv =====
// Interface: k-mer length configuration write channel.
`default_nettype none

interface ckmer_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ckmer_front.sv =====
// Front end: accepts bases, rolls the forward and reverse-complement words.
`default_nettype none

module ckmer_front
  import ckmer_pkg::*;
#(
  parameter int unsigned POS_BITS = 32
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  ckmer_in_if.sink          in_i,
  ckmer_cfg_if.sink         cfg_i,
  input  ckmer_q_stat_t     stat_i,
  output logic              push_o,
  output ckmer_item_t       item_o
);

  logic [WordW-1:0]    fwd_q, fwd_d;
  logic [WordW-1:0]    rc_q, rc_d;
  logic [WordW-1:0]    mask_q;
  logic [KIdxW-1:0]    km1_q;
  logic [KLenW-1:0]    fill_q, fill_d;
  logic [POS_BITS-1:0] idx_q;
  logic [POS_BITS-1:0] start_full;
  logic                in_fire, cfg_fire, emit;

  // Hold bases while a length write is offered so the two never transfer together.
  assign in_i.ready  = !stat_i.full && !cfg_i.valid;
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  // A k-mer is complete once k-1 bases of this contig are already held.
  assign emit = fill_q >= {1'b0, km1_q};

  always_comb begin
    fwd_d = ((fwd_q << 2) | {{(WordW-2){1'b0}}, in_i.base}) & mask_q;
    rc_d  = rc_q >> 2;
    for (int i = 0; i < KMaxPairs; i++) begin
      if (KIdxW'(i) == km1_q) begin
        rc_d[2*i +: 2] = ~in_i.base;
      end
    end
    fill_d = emit ? (KLenW'(km1_q) + 6'd1) : (fill_q + 6'd1);
  end

  assign start_full = idx_q - POS_BITS'(km1_q);

  always_comb begin
    item_o.fwd_word  = fwd_d;
    item_o.rc_word   = rc_d;
    item_o.start_pos = OutPosW'(start_full);
    item_o.last      = in_i.contig_end;
  end

  assign push_o = in_fire && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= '0;
      rc_q   <= '0;
      fill_q <= '0;
      idx_q  <= '0;
      km1_q  <= KM1Reset;
      mask_q <= word_mask(KM1Reset);
    end else if (cfg_fire) begin
      // New length: restart the k-mer, keep the base index.
      km1_q  <= eff_km1(cfg_i.data);
      mask_q <= word_mask(eff_km1(cfg_i.data));
      fwd_q  <= '0;
      rc_q   <= '0;
      fill_q <= '0;
    end else if (in_fire) begin
      idx_q <= idx_q + POS_BITS'(1);
      if (in_i.contig_end) begin
        fwd_q  <= '0;
        rc_q   <= '0;
        fill_q <= '0;
      end else begin
        fwd_q  <= fwd_d;
        rc_q   <= rc_d;
        fill_q <= fill_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ckmer_fifo.sv =====
// Two-entry queue between the front end and the back end.
`default_nettype none

module ckmer_fifo
  import ckmer_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  input  logic          push_i,
  input  ckmer_item_t   item_i,
  input  logic          pop_i,
  output ckmer_item_t   item_o,
  output ckmer_q_stat_t stat_o
);

  ckmer_item_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;
  assign item_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ckmer_back.sv =====
// Back end: picks the canonical word and holds the result register.
`default_nettype none

module ckmer_back
  import ckmer_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  input  ckmer_item_t   item_i,
  input  ckmer_q_stat_t stat_i,
  output logic          pop_o,
  ckmer_out_if.source   out_o
);

  logic               valid_q;
  logic [WordW-1:0]   word_q;
  logic [OutPosW-1:0] pos_q;
  logic               fwd_q, last_q;
  logic               fwd_le;

  // Load when the result register is empty or its transfer completes.
  assign pop_o  = !stat_i.empty && (!valid_q || out_o.ready);
  assign fwd_le = item_i.fwd_word <= item_i.rc_word;

  assign out_o.valid                = valid_q;
  assign out_o.canonical_word       = word_q;
  assign out_o.start_pos            = pos_q;
  assign out_o.forward_is_canonical = fwd_q;
  assign out_o.last_of_contig       = last_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q <= fwd_le ? item_i.fwd_word : item_i.rc_word;
      pos_q  <= item_i.start_pos;
      fwd_q  <= fwd_le;
      last_q <= item_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/contig_canonical_kmer_stream.sv =====
// Top level: canonical k-mer extraction over a stream of concatenated contigs.
// Path: the completing base's item is written to the queue, then to the result register.
// Throughput: one base per cycle unless the queue is full or a length write is offered.
// Front end: rolling shift; back end: 64-bit compare; a two-entry queue between them.
// Reset: rst_ni clears words, fill count, base index and queue; length is 31.
`default_nettype none

module contig_canonical_kmer_stream
  import ckmer_pkg::*;
#(
  parameter int unsigned POS_BITS = 32
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  ckmer_in_if.sink     in_i,
  ckmer_cfg_if.sink    cfg_i,
  ckmer_out_if.source  out_o
);

  logic          push, pop;
  ckmer_item_t   push_item, pop_item;
  ckmer_q_stat_t q_stat;

  ckmer_front #(
    .POS_BITS(POS_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .stat_i (q_stat),
    .push_o (push),
    .item_o (push_item)
  );

  ckmer_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (q_stat)
  );

  ckmer_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (pop_item),
    .stat_i (q_stat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  a_q_stat_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("push into a full queue");

  a_result_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!q_stat.empty))
    else $error("result offered without a queued item");

endmodule

`default_nettype wire
